/* rtl/idtu_pkg.sv */
package idtu_pkg;

    // operation codes on the func field
    localparam logic [2:0] FUNC_SIN  = 3'd0;
    localparam logic [2:0] FUNC_COS  = 3'd1;
    localparam logic [2:0] FUNC_TAN  = 3'd2;
    localparam logic [2:0] FUNC_ASIN = 3'd3;
    localparam logic [2:0] FUNC_ACOS = 3'd4;
    localparam logic [2:0] FUNC_ATAN = 3'd5;

    // what is still to be done with an item after the front end
    localparam logic [2:0] KIND_DIRECT = 3'd0;
    localparam logic [2:0] KIND_TAN    = 3'd1;
    localparam logic [2:0] KIND_ASIN   = 3'd2;
    localparam logic [2:0] KIND_ACOS   = 3'd3;
    localparam logic [2:0] KIND_ATAN   = 3'd4;

    // divider geometry: one quotient bit per stage
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 16;
    localparam int DIV_QW = 16;

    // control carried alongside each item through the pipeline
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [16:0] value;
        logic               dz;
        logic               neg;
        logic               flip;
        logic               clamp;
    } t_side;

    // cos(k degrees) * 10000 for k = 0..90
    function automatic logic [13:0] cos_tab(input logic [6:0] k);
        logic [13:0] v;
        unique case (k)
            7'd0: v = 14'd10000;  7'd1: v = 14'd9998;   7'd2: v = 14'd9994;
            7'd3: v = 14'd9986;   7'd4: v = 14'd9976;   7'd5: v = 14'd9962;
            7'd6: v = 14'd9945;   7'd7: v = 14'd9925;   7'd8: v = 14'd9903;
            7'd9: v = 14'd9877;   7'd10: v = 14'd9848;  7'd11: v = 14'd9816;
            7'd12: v = 14'd9781;  7'd13: v = 14'd9744;  7'd14: v = 14'd9703;
            7'd15: v = 14'd9659;  7'd16: v = 14'd9613;  7'd17: v = 14'd9563;
            7'd18: v = 14'd9511;  7'd19: v = 14'd9455;  7'd20: v = 14'd9397;
            7'd21: v = 14'd9336;  7'd22: v = 14'd9272;  7'd23: v = 14'd9205;
            7'd24: v = 14'd9135;  7'd25: v = 14'd9063;  7'd26: v = 14'd8988;
            7'd27: v = 14'd8910;  7'd28: v = 14'd8829;  7'd29: v = 14'd8746;
            7'd30: v = 14'd8660;  7'd31: v = 14'd8572;  7'd32: v = 14'd8480;
            7'd33: v = 14'd8387;  7'd34: v = 14'd8290;  7'd35: v = 14'd8192;
            7'd36: v = 14'd8090;  7'd37: v = 14'd7986;  7'd38: v = 14'd7880;
            7'd39: v = 14'd7771;  7'd40: v = 14'd7660;  7'd41: v = 14'd7547;
            7'd42: v = 14'd7431;  7'd43: v = 14'd7314;  7'd44: v = 14'd7193;
            7'd45: v = 14'd7071;  7'd46: v = 14'd6947;  7'd47: v = 14'd6820;
            7'd48: v = 14'd6691;  7'd49: v = 14'd6561;  7'd50: v = 14'd6428;
            7'd51: v = 14'd6293;  7'd52: v = 14'd6157;  7'd53: v = 14'd6018;
            7'd54: v = 14'd5878;  7'd55: v = 14'd5736;  7'd56: v = 14'd5592;
            7'd57: v = 14'd5446;  7'd58: v = 14'd5299;  7'd59: v = 14'd5150;
            7'd60: v = 14'd5000;  7'd61: v = 14'd4848;  7'd62: v = 14'd4695;
            7'd63: v = 14'd4540;  7'd64: v = 14'd4384;  7'd65: v = 14'd4226;
            7'd66: v = 14'd4067;  7'd67: v = 14'd3907;  7'd68: v = 14'd3746;
            7'd69: v = 14'd3584;  7'd70: v = 14'd3420;  7'd71: v = 14'd3256;
            7'd72: v = 14'd3090;  7'd73: v = 14'd2924;  7'd74: v = 14'd2756;
            7'd75: v = 14'd2588;  7'd76: v = 14'd2419;  7'd77: v = 14'd2250;
            7'd78: v = 14'd2079;  7'd79: v = 14'd1908;  7'd80: v = 14'd1736;
            7'd81: v = 14'd1564;  7'd82: v = 14'd1392;  7'd83: v = 14'd1219;
            7'd84: v = 14'd1045;  7'd85: v = 14'd872;   7'd86: v = 14'd698;
            7'd87: v = 14'd523;   7'd88: v = 14'd349;   7'd89: v = 14'd175;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // exact floor(v / 10) for v up to 10000, by reciprocal
    function automatic logic [9:0] div10(input logic [13:0] v);
        logic [26:0] p;
        p = {13'b0, v} * 27'd6554;
        return p[25:16];
    endfunction

endpackage

/* rtl/integer_degree_trig_unit.sv */
// Integer trigonometry over whole degrees: sin, cos and tan in thousandths,
// asin, acos and atan in whole degrees, chosen per item by the func field.
// The block is a fixed pipeline of 43 register stages: four front-end
// stages (angle reduction modulo 360, operand folding, table lookup), a
// 16-stage restoring divider, six stages for the table search and the atan
// denominator, a second 16-stage divider for atan and one output register.
// One item can enter every cycle while the output is not stalled; a stalled
// output holds the whole pipeline in place.
module integer_degree_trig_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_func,
    input  logic signed [15:0] i_angle_or_opposite,
    input  logic signed [15:0] i_adjacent,
    input  logic signed [15:0] i_hypotenuse,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [16:0] o_value,
    output logic               o_divide_by_zero
);

    logic en;

    logic               r_out_valid;
    logic signed [16:0] r_out_value;
    logic               r_out_dz;

    // whole pipeline advances unless the output holds an untaken result
    assign en      = ~r_out_valid | i_ready;
    assign o_ready = en;

    // ---------------- stage 1: register inputs, start modulo 360
    logic signed [17:0] n1_ush;
    logic [16:0]        n1_u;
    logic [15:0]        n1_abs_a, n1_abs_x, n1_abs_h;

    logic               r1_valid;
    logic [2:0]         r1_func;
    logic signed [15:0] r1_a, r1_x, r1_h;
    logic [15:0]        r1_abs_a, r1_abs_x, r1_abs_h;
    logic [16:0]        r1_u;
    logic [33:0]        r1_prod;

    // offset by a multiple of 360 so the angle is positive
    assign n1_ush   = {{2{i_angle_or_opposite[15]}}, i_angle_or_opposite} + 18'sd33120;
    assign n1_u     = n1_ush[16:0];
    assign n1_abs_a = i_angle_or_opposite[15] ? (~i_angle_or_opposite + 16'd1)
                                              : i_angle_or_opposite;
    assign n1_abs_x = i_adjacent[15] ? (~i_adjacent + 16'd1) : i_adjacent;
    assign n1_abs_h = i_hypotenuse[15] ? (~i_hypotenuse + 16'd1) : i_hypotenuse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_func  <= i_func;
            r1_a     <= i_angle_or_opposite;
            r1_x     <= i_adjacent;
            r1_h     <= i_hypotenuse;
            r1_abs_a <= n1_abs_a;
            r1_abs_x <= n1_abs_x;
            r1_abs_h <= n1_abs_h;
            r1_u     <= n1_u;
            r1_prod  <= {17'b0, n1_u} * 34'd93206;
        end
    end

    // ---------------- stage 2: remainder estimate, inverse operand folding
    logic [8:0]         n2_qe;
    logic [16:0]        n2_qx;
    logic [16:0]        n2_rem;
    logic [15:0]        n2_big, n2_small;
    logic               n2_flip_c;
    idtu_pkg::t_side    n2_side;
    logic [31:0]        n2_dividend;
    logic [15:0]        n2_divisor;

    logic               r2_valid;
    logic [2:0]         r2_func;
    logic [9:0]         r2_r0;
    idtu_pkg::t_side    r2_side;
    logic [31:0]        r2_dividend;
    logic [15:0]        r2_divisor;

    assign n2_qe  = r1_prod[33:25];
    assign n2_qx  = {8'b0, n2_qe} * 17'd360;
    assign n2_rem = r1_u - n2_qx;

    assign n2_flip_c = r1_abs_x < r1_abs_a;
    assign n2_big    = n2_flip_c ? r1_abs_a : r1_abs_x;
    assign n2_small  = n2_flip_c ? r1_abs_x : r1_abs_a;

    // asin, acos and atan: special cases and divider operands
    always_comb begin
        n2_side        = '0;
        n2_side.kind   = idtu_pkg::KIND_DIRECT;
        n2_dividend    = '0;
        n2_divisor     = '0;
        if (r1_func == idtu_pkg::FUNC_ASIN) begin
            if (r1_a > r1_h || r1_a == 16'sd0) begin
                n2_side.value = 17'sd0;
            end else if (r1_h == 16'sd0) begin
                n2_side.dz = 1'b1;
            end else begin
                n2_side.kind  = idtu_pkg::KIND_ASIN;
                n2_side.neg   = r1_a[15] ^ r1_h[15];
                n2_side.clamp = r1_abs_a >= r1_abs_h;
                n2_dividend   = {16'b0, r1_abs_a} * 32'd10000;
                n2_divisor    = r1_abs_h;
            end
        end else if (r1_func == idtu_pkg::FUNC_ACOS) begin
            if (r1_x > r1_h) begin
                n2_side.value = 17'sd0;
            end else if (r1_x == 16'sd0) begin
                n2_side.value = r1_h[15] ? -17'sd90 : 17'sd90;
            end else if (r1_h == 16'sd0) begin
                n2_side.dz = 1'b1;
            end else begin
                n2_side.kind  = idtu_pkg::KIND_ACOS;
                n2_side.neg   = r1_x[15] ^ r1_h[15];
                n2_side.clamp = r1_abs_x >= r1_abs_h;
                n2_dividend   = {16'b0, r1_abs_x} * 32'd10000;
                n2_divisor    = r1_abs_h;
            end
        end else if (r1_func == idtu_pkg::FUNC_ATAN) begin
            if (n2_big == 16'd0) begin
                n2_side.value = 17'sd90;
            end else begin
                n2_side.kind = idtu_pkg::KIND_ATAN;
                n2_side.flip = n2_flip_c;
                n2_dividend  = {16'b0, n2_small} * 32'd1000;
                n2_divisor   = n2_big;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_func     <= r1_func;
            r2_r0       <= n2_rem[9:0];
            r2_side     <= n2_side;
            r2_dividend <= n2_dividend;
            r2_divisor  <= n2_divisor;
        end
    end

    // ---------------- stage 3: final correction of the reduced angle
    logic               r3_valid;
    logic [2:0]         r3_func;
    logic [8:0]         r3_d;
    idtu_pkg::t_side    r3_side;
    logic [31:0]        r3_dividend;
    logic [15:0]        r3_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_func     <= r2_func;
            r3_d        <= (r2_r0 >= 10'd360) ? 9'(r2_r0 - 10'd360) : r2_r0[8:0];
            r3_side     <= r2_side;
            r3_dividend <= r2_dividend;
            r3_divisor  <= r2_divisor;
        end
    end

    // ---------------- stage 4: quadrant mapping and table lookup
    logic [6:0]         n4_s_idx, n4_c_idx;
    logic               n4_s_neg, n4_c_neg;
    logic [9:0]         n4_s_val, n4_c_val;
    idtu_pkg::t_side    n4_side;
    logic [31:0]        n4_dividend;
    logic [15:0]        n4_divisor;

    logic               r4_valid;
    idtu_pkg::t_side    r4_side;
    logic [31:0]        r4_dividend;
    logic [15:0]        r4_divisor;

    // table indexes and signs of sin and cos for each quadrant
    always_comb begin
        priority if (r3_d < 9'd90) begin
            n4_s_idx = 7'(9'd90 - r3_d);   n4_s_neg = 1'b0;
            n4_c_idx = r3_d[6:0];          n4_c_neg = 1'b0;
        end else if (r3_d < 9'd180) begin
            n4_s_idx = 7'(r3_d - 9'd90);   n4_s_neg = 1'b0;
            n4_c_idx = 7'(9'd180 - r3_d);  n4_c_neg = 1'b1;
        end else if (r3_d < 9'd270) begin
            n4_s_idx = 7'(9'd270 - r3_d);  n4_s_neg = 1'b1;
            n4_c_idx = 7'(r3_d - 9'd180);  n4_c_neg = 1'b1;
        end else begin
            n4_s_idx = 7'(r3_d - 9'd270);  n4_s_neg = 1'b1;
            n4_c_idx = 7'(9'd360 - r3_d);  n4_c_neg = 1'b0;
        end
    end

    assign n4_s_val = idtu_pkg::div10(idtu_pkg::cos_tab(n4_s_idx));
    assign n4_c_val = idtu_pkg::div10(idtu_pkg::cos_tab(n4_c_idx));

    // merge trig results with the inverse path
    always_comb begin
        n4_side     = r3_side;
        n4_dividend = r3_dividend;
        n4_divisor  = r3_divisor;
        if (r3_func == idtu_pkg::FUNC_SIN) begin
            n4_side.value = n4_s_neg ? -$signed({7'b0, n4_s_val}) : $signed({7'b0, n4_s_val});
        end else if (r3_func == idtu_pkg::FUNC_COS) begin
            n4_side.value = n4_c_neg ? -$signed({7'b0, n4_c_val}) : $signed({7'b0, n4_c_val});
        end else if (r3_func == idtu_pkg::FUNC_TAN) begin
            if (r3_d == 9'd90) begin
                n4_side.value = 17'sd9999;
            end else if (r3_d == 9'd270) begin
                n4_side.value = -17'sd9999;
            end else begin
                n4_side.kind = idtu_pkg::KIND_TAN;
                n4_side.neg  = n4_s_neg ^ n4_c_neg;
                n4_dividend  = {18'b0, idtu_pkg::cos_tab(n4_s_idx)} * 32'd1000;
                n4_divisor   = {2'b0, idtu_pkg::cos_tab(n4_c_idx)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side     <= n4_side;
            r4_dividend <= n4_dividend;
            r4_divisor  <= n4_divisor;
        end
    end

    // ---------------- first divider: tan, asin/acos ratio, atan ratio
    logic               d1_valid;
    idtu_pkg::t_side    d1_side;
    logic [15:0]        d1_quot;

    idtu_div u_div1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r4_valid),
        .i_side     (r4_side),
        .i_dividend (r4_dividend),
        .i_divisor  (r4_divisor),
        .o_valid    (d1_valid),
        .o_side     (d1_side),
        .o_quot     (d1_quot)
    );

    // ---------------- stage A1: tan sign, table compares, 1764 * t
    logic [13:0]        na1_qc;
    logic [89:0]        na1_therm;
    idtu_pkg::t_side    na1_side;

    logic               ra1_valid;
    idtu_pkg::t_side    ra1_side;
    logic [9:0]         ra1_q;
    logic [89:0]        ra1_therm;
    logic [20:0]        ra1_p1;

    assign na1_qc = d1_side.clamp ? 14'd9999 : d1_quot[13:0];

    // one compare per table entry from 1 to 90
    always_comb begin
        for (int j = 1; j <= 90; j++) begin
            na1_therm[j-1] = idtu_pkg::cos_tab(7'(j)) > na1_qc;
        end
    end

    always_comb begin
        na1_side = d1_side;
        if (d1_side.kind == idtu_pkg::KIND_TAN) begin
            na1_side.kind  = idtu_pkg::KIND_DIRECT;
            na1_side.value = d1_side.neg ? -$signed({1'b0, d1_quot}) : $signed({1'b0, d1_quot});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra1_valid <= 1'b0;
        end else if (en) begin
            ra1_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra1_side  <= na1_side;
            ra1_q     <= d1_quot[9:0];
            ra1_therm <= na1_therm;
            ra1_p1    <= {11'b0, d1_quot[9:0]} * 21'd1764;
        end
    end

    // ---------------- stage A2: interval index, first divide by 1000
    logic [127:0]       na2_ext;
    logic [6:0]         na2_k;
    logic [6:0]         na2_cand;
    logic [6:0]         na2_ang;
    logic [32:0]        na2_m;
    idtu_pkg::t_side    na2_side;

    logic               ra2_valid;
    idtu_pkg::t_side    ra2_side;
    logic [9:0]         ra2_q;
    logic [20:0]        ra2_p1;
    logic [11:0]        ra2_qe;

    assign na2_ext = {38'b0, ra1_therm};

    // binary search for the last set bit of the thermometer
    always_comb begin
        na2_k    = 7'd0;
        na2_cand = 7'd0;
        for (int b = 6; b >= 0; b--) begin
            na2_cand = na2_k + 7'(1 << b);
            if (na2_ext[na2_cand - 7'd1]) begin
                na2_k = na2_cand;
            end
        end
    end

    assign na2_ang = (ra1_side.kind == idtu_pkg::KIND_ASIN) ? 7'(7'd90 - na2_k) : na2_k;
    assign na2_m   = {12'b0, ra1_p1} * 33'd2097;

    always_comb begin
        na2_side = ra1_side;
        if (ra1_side.kind == idtu_pkg::KIND_ASIN || ra1_side.kind == idtu_pkg::KIND_ACOS) begin
            na2_side.kind  = idtu_pkg::KIND_DIRECT;
            na2_side.value = ra1_side.neg ? -$signed({10'b0, na2_ang})
                                          : $signed({10'b0, na2_ang});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra2_valid <= 1'b0;
        end else if (en) begin
            ra2_valid <= ra1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra2_side <= na2_side;
            ra2_q    <= ra1_q;
            ra2_p1   <= ra1_p1;
            ra2_qe   <= na2_m[32:21];
        end
    end

    // ---------------- stage A3: correct first quotient by 1000
    logic [20:0]        na3_r;

    logic               ra3_valid;
    idtu_pkg::t_side    ra3_side;
    logic [9:0]         ra3_q;
    logic [10:0]        ra3_c1;

    assign na3_r = ra2_p1 - ({9'b0, ra2_qe} * 21'd1000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra3_valid <= 1'b0;
        end else if (en) begin
            ra3_valid <= ra2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra3_side <= ra2_side;
            ra3_q    <= ra2_q;
            ra3_c1   <= (na3_r >= 21'd1000) ? 11'(ra2_qe + 12'd1) : ra2_qe[10:0];
        end
    end

    // ---------------- stage A4: second product with t
    logic               ra4_valid;
    idtu_pkg::t_side    ra4_side;
    logic [9:0]         ra4_q;
    logic [20:0]        ra4_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra4_valid <= 1'b0;
        end else if (en) begin
            ra4_valid <= ra3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra4_side <= ra3_side;
            ra4_q    <= ra3_q;
            ra4_p2   <= {10'b0, ra3_c1} * {11'b0, ra3_q};
        end
    end

    // ---------------- stage A5: second divide by 1000 estimate
    logic [32:0]        na5_m;

    logic               ra5_valid;
    idtu_pkg::t_side    ra5_side;
    logic [9:0]         ra5_q;
    logic [20:0]        ra5_p2;
    logic [11:0]        ra5_qe;

    assign na5_m = {12'b0, ra4_p2} * 33'd2097;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra5_valid <= 1'b0;
        end else if (en) begin
            ra5_valid <= ra4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra5_side <= ra4_side;
            ra5_q    <= ra4_q;
            ra5_p2   <= ra4_p2;
            ra5_qe   <= na5_m[32:21];
        end
    end

    // ---------------- stage A6: denominator and atan divider operands
    logic [20:0]        na6_r;
    logic [11:0]        na6_c2;

    logic               ra6_valid;
    idtu_pkg::t_side    ra6_side;
    logic [31:0]        ra6_dividend;
    logic [15:0]        ra6_divisor;

    assign na6_r  = ra5_p2 - ({9'b0, ra5_qe} * 21'd1000);
    assign na6_c2 = (na6_r >= 21'd1000) ? (ra5_qe + 12'd1) : ra5_qe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra6_valid <= 1'b0;
        end else if (en) begin
            ra6_valid <= ra5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra6_side     <= ra5_side;
            ra6_dividend <= {22'b0, ra5_q} * 32'd360;
            ra6_divisor  <= 16'd6283 + {4'b0, na6_c2};
        end
    end

    // ---------------- second divider: atan angle
    logic               d2_valid;
    idtu_pkg::t_side    d2_side;
    logic [15:0]        d2_quot;

    idtu_div u_div2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (ra6_valid),
        .i_side     (ra6_side),
        .i_dividend (ra6_dividend),
        .i_divisor  (ra6_divisor),
        .o_valid    (d2_valid),
        .o_side     (d2_side),
        .o_quot     (d2_quot)
    );

    // ---------------- output register: octant unfold for atan
    logic [6:0]         n_out_ang;
    logic signed [16:0] n_out_value;

    assign n_out_ang = d2_side.flip ? 7'(7'd90 - d2_quot[6:0]) : d2_quot[6:0];

    always_comb begin
        n_out_value = d2_side.value;
        if (d2_side.kind == idtu_pkg::KIND_ATAN) begin
            n_out_value = $signed({10'b0, n_out_ang});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_value <= n_out_value;
            r_out_dz    <= d2_side.dz;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_value          = r_out_value;
    assign o_divide_by_zero = r_out_dz;

endmodule

/* rtl/idtu_div.sv */
module idtu_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  idtu_pkg::t_side                 i_side,
    input  logic [idtu_pkg::DIV_NW-1:0]     i_dividend,
    input  logic [idtu_pkg::DIV_DW-1:0]     i_divisor,
    output logic                            o_valid,
    output idtu_pkg::t_side                 o_side,
    output logic [idtu_pkg::DIV_QW-1:0]     o_quot
);

    localparam int NW = idtu_pkg::DIV_NW;
    localparam int DW = idtu_pkg::DIV_DW;
    localparam int QW = idtu_pkg::DIV_QW;

    logic                  r_valid [QW];
    idtu_pkg::t_side       r_side  [QW];
    logic [NW-1:0]         r_rem   [QW];
    logic [DW-1:0]         r_div   [QW];
    logic [QW-1:0]         r_quot  [QW];

    // restoring division, one quotient bit per stage, most significant first
    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic                  v_in;
        idtu_pkg::t_side       side_in;
        logic [NW-1:0]         rem_in;
        logic [DW-1:0]         div_in;
        logic [QW-1:0]         quot_in;
        logic [NW:0]           trial;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign rem_in  = i_dividend;
            assign div_in  = i_divisor;
            assign quot_in = '0;
        end else begin : g_next
            assign v_in    = r_valid[g-1];
            assign side_in = r_side[g-1];
            assign rem_in  = r_rem[g-1];
            assign div_in  = r_div[g-1];
            assign quot_in = r_quot[g-1];
        end

        // trial subtract of the divisor aligned to this bit
        assign trial = {1'b0, rem_in} - ({{(NW+1-DW){1'b0}}, div_in} << (QW-1-g));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= side_in;
                r_div[g]  <= div_in;
                r_rem[g]  <= trial[NW] ? rem_in : trial[NW-1:0];
                r_quot[g] <= {quot_in[QW-2:0], ~trial[NW]};
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_quot  = r_quot[QW-1];

endmodule
